>>> hw/rtl/cell_list_neighbor_search_core_defines.svh
// assertion macros shared by the cell list search core
// no dependencies; included by files that carry checks
`ifndef CELL_LIST_NEIGHBOR_SEARCH_CORE_DEFINES_SVH
`define CELL_LIST_NEIGHBOR_SEARCH_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define CLNS_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define CLNS_ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) pre |=> post) else $error(msg);
`else
`define CLNS_ASSERT(lbl, clk, rst_n, prop, msg)
`define CLNS_ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg)
`endif
`endif

>>> hw/rtl/clns_pkg.sv
// shared types, constants and helpers of the cell list search core
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package clns_pkg;
  localparam int MAX_CELLS_SIDE = 64;
  localparam int MAX_PER_CELL   = 4;
  localparam int MAX_PARTICLES  = 1024;
  localparam int NUM_CELLS      = MAX_CELLS_SIDE * MAX_CELLS_SIDE;
  localparam int COORD_W        = $clog2(MAX_CELLS_SIDE);
  localparam int SIDE_W         = 7;
  localparam int CELL_W         = 2 * COORD_W;
  localparam int IDX_W          = 10;
  localparam int TOTAL_W        = $clog2(MAX_PARTICLES + 1);
  localparam int PIDX_W         = $clog2(MAX_PARTICLES);
  localparam int FILL_W         = $clog2(MAX_PER_CELL + 1);
  localparam int SLOT_W         = (MAX_PER_CELL > 1) ? $clog2(MAX_PER_CELL) : 1;
  localparam int MEM_AW         = CELL_W + SLOT_W;
  localparam int POS_W          = 16;
  localparam int NB_LAST        = 8;
  localparam int QDEPTH         = 4;
  localparam int QPTR_W         = $clog2(QDEPTH);

  typedef enum logic [1:0] {K_INSERT = 2'd0, K_QUERY = 2'd1, K_CLEAR = 2'd2} kind_t;

  typedef enum logic [2:0] {
    ST_OK = 3'd0, ST_CELL_FULL = 3'd1, ST_TABLE_FULL = 3'd2,
    ST_UNKNOWN = 3'd3, ST_NO_ENTRY = 3'd4
  } status_t;

  typedef enum logic [1:0] {CFG_CELL_SIZE = 2'd0, CFG_ACROSS = 2'd1, CFG_DOWN = 2'd2} cfg_idx_t;

  typedef enum logic [1:0] {F_IDLE, F_DIV, F_PUSH} front_state_t;

  typedef enum logic [3:0] {
    B_INIT, B_IDLE, B_INS_RD, B_INS_CHK, B_EMIT, B_CLR,
    B_Q_HOME, B_Q_CELL, B_Q_FILL, B_Q_SLOT, B_Q_MEM, B_Q_END
  } back_state_t;

  typedef struct packed {
    kind_t               kind;
    logic [COORD_W-1:0]  cx;
    logic [COORD_W-1:0]  cy;
    logic [IDX_W-1:0]    pidx;
  } cmd_t;

  typedef struct packed {
    logic [POS_W-1:0] rem;
    logic [POS_W-1:0] quo;
  } div_t;

  typedef struct packed {
    logic [1:0] dx;
    logic [1:0] dy;
  } nb_off_t;

  // one restoring division step, dividend bits shift out of quo
  function automatic div_t div_step(input div_t cur, input logic [POS_W-1:0] dv);
    logic [POS_W:0] t;
    div_t r;
    t = {cur.rem, cur.quo[POS_W-1]};
    r.quo = {cur.quo[POS_W-2:0], 1'b0};
    if (t >= {1'b0, dv}) begin
      t = t - {1'b0, dv};
      r.quo[0] = 1'b1;
    end
    r.rem = t[POS_W-1:0];
    return r;
  endfunction

  function automatic logic [SIDE_W-1:0] clamp_side(input logic [SIDE_W-1:0] v);
    if (v == '0) return SIDE_W'(1);
    if (v > SIDE_W'(MAX_CELLS_SIDE)) return SIDE_W'(MAX_CELLS_SIDE);
    return v;
  endfunction

  // visiting order: left, right, lower row, upper row, own cell
  function automatic nb_off_t nb_offset(input logic [3:0] nb);
    nb_off_t o;
    case (nb)
      4'd0: o = '{dx: 2'b11, dy: 2'b00};
      4'd1: o = '{dx: 2'b01, dy: 2'b00};
      4'd2: o = '{dx: 2'b11, dy: 2'b11};
      4'd3: o = '{dx: 2'b00, dy: 2'b11};
      4'd4: o = '{dx: 2'b01, dy: 2'b11};
      4'd5: o = '{dx: 2'b11, dy: 2'b01};
      4'd6: o = '{dx: 2'b00, dy: 2'b01};
      4'd7: o = '{dx: 2'b01, dy: 2'b01};
      default: o = '{dx: 2'b00, dy: 2'b00};
    endcase
    return o;
  endfunction
endpackage
`default_nettype wire

>>> hw/rtl/clns_front.sv
// front end: accepts beats, bins insert coordinates by serial division
// depends on clns_pkg
`timescale 1ns / 1ps
`default_nettype none
module clns_front (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [1:0]                    in_kind,
  input  wire logic [clns_pkg::POS_W-1:0]    in_pos_x,
  input  wire logic [clns_pkg::POS_W-1:0]    in_pos_y,
  input  wire logic [clns_pkg::IDX_W-1:0]    in_pidx,
  input  wire logic [clns_pkg::POS_W-1:0]    cell_size,
  input  wire logic [clns_pkg::SIDE_W-1:0]   across,
  input  wire logic [clns_pkg::SIDE_W-1:0]   down,
  input  wire logic                          busy,
  input  wire logic                          q_full,
  output logic                               q_push,
  output clns_pkg::cmd_t                     q_cmd
);
  import clns_pkg::*;

  front_state_t st_r, st_nxt;
  div_t dx_r, dx_nxt, dy_r, dy_nxt;
  logic [POS_W-1:0] dv_r, dv_nxt;
  logic [3:0] cnt_r, cnt_nxt;
  logic acc;
  logic [COORD_W-1:0] cx, cy;

  assign in_ready = (st_r == F_IDLE) && !q_full && !busy;
  assign acc = in_valid && in_ready;

  // saturate quotients to the last cell in use
  always_comb begin
    cx = (dx_r.quo >= {{(POS_W-SIDE_W){1'b0}}, across}) ? COORD_W'(across - 1'b1)
                                                        : dx_r.quo[COORD_W-1:0];
    cy = (dy_r.quo >= {{(POS_W-SIDE_W){1'b0}}, down}) ? COORD_W'(down - 1'b1)
                                                      : dy_r.quo[COORD_W-1:0];
  end

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      F_IDLE: if (acc && in_kind == K_INSERT) st_nxt = F_DIV;
      F_DIV:  if (cnt_r == 4'd15) st_nxt = F_PUSH;
      F_PUSH: if (!q_full) st_nxt = F_IDLE;
      default: st_nxt = F_IDLE;
    endcase
  end

  always_comb begin
    dx_nxt = dx_r;
    dy_nxt = dy_r;
    dv_nxt = dv_r;
    cnt_nxt = cnt_r;
    q_push = 1'b0;
    q_cmd = '{kind: K_INSERT, cx: cx, cy: cy, pidx: '0};
    case (st_r)
      F_IDLE: begin
        dx_nxt = '{rem: '0, quo: in_pos_x};
        dy_nxt = '{rem: '0, quo: in_pos_y};
        dv_nxt = (cell_size == '0) ? POS_W'(1) : cell_size;
        cnt_nxt = '0;
        if (acc && (in_kind == K_QUERY || in_kind == K_CLEAR)) begin
          q_push = 1'b1;
          q_cmd = '{kind: kind_t'(in_kind), cx: '0, cy: '0, pidx: in_pidx};
        end
      end
      F_DIV: begin
        dx_nxt = div_step(dx_r, dv_r);
        dy_nxt = div_step(dy_r, dv_r);
        cnt_nxt = cnt_r + 4'd1;
      end
      F_PUSH: q_push = !q_full;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= F_IDLE;
      cnt_r <= '0;
    end else begin
      st_r <= st_nxt;
      cnt_r <= cnt_nxt;
    end
    dx_r <= dx_nxt;
    dy_r <= dy_nxt;
    dv_r <= dv_nxt;
  end
endmodule
`default_nettype wire

>>> hw/rtl/clns_fifo.sv
// short command queue between front and back ends
// depends on clns_pkg
`timescale 1ns / 1ps
`default_nettype none
module clns_fifo (
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    push,
  input  wire clns_pkg::cmd_t din,
  input  wire logic    pop,
  output clns_pkg::cmd_t dout,
  output logic         full,
  output logic         empty
);
  import clns_pkg::*;

  cmd_t slots_r [QDEPTH];
  logic [QPTR_W-1:0] wp_r, wp_nxt, rp_r, rp_nxt;
  logic [QPTR_W:0] cnt_r, cnt_nxt;

  assign full  = (cnt_r == (QPTR_W+1)'(QDEPTH));
  assign empty = (cnt_r == '0);
  assign dout  = slots_r[rp_r];

  always_comb begin
    wp_nxt = push ? wp_r + 1'b1 : wp_r;
    rp_nxt = pop ? rp_r + 1'b1 : rp_r;
    cnt_nxt = cnt_r + (QPTR_W+1)'(push) - (QPTR_W+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0;
      rp_r <= '0;
      cnt_r <= '0;
    end else begin
      wp_r <= wp_nxt;
      rp_r <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
    if (push) slots_r[wp_r] <= din;
  end
endmodule
`default_nettype wire

>>> hw/rtl/clns_back.sv
// back end: grid memories, insert bookkeeping, neighbourhood walk, result register
// depends on clns_pkg and the assertion macro header
`timescale 1ns / 1ps
`default_nettype none
`include "cell_list_neighbor_search_core_defines.svh"
module clns_back (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        cmd_valid,
  input  wire clns_pkg::cmd_t              cmd,
  output logic                             cmd_pop,
  input  wire logic [clns_pkg::SIDE_W-1:0] across,
  input  wire logic [clns_pkg::SIDE_W-1:0] down,
  output logic                             busy,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic [clns_pkg::IDX_W-1:0]       out_idx,
  output logic [2:0]                       out_status,
  output logic                             out_last
);
  import clns_pkg::*;

  logic [FILL_W-1:0] fill_mem [NUM_CELLS];
  logic [IDX_W-1:0]  memb_mem [NUM_CELLS * MAX_PER_CELL];
  logic [CELL_W-1:0] home_mem [MAX_PARTICLES];

  back_state_t st_r, st_nxt;
  cmd_t cmd_r, cmd_nxt;
  logic [CELL_W:0] sweep_r, sweep_nxt;
  logic [TOTAL_W-1:0] total_r, total_nxt;
  logic [COORD_W-1:0] cx_r, cx_nxt, cy_r, cy_nxt;
  logic [CELL_W-1:0] ncell_r, ncell_nxt;
  logic [3:0] nb_r, nb_nxt;
  logic [FILL_W-1:0] n_r, n_nxt, s_r, s_nxt;
  logic hold_v_r, hold_v_nxt;
  logic [IDX_W-1:0] hold_r, hold_nxt;
  logic [IDX_W-1:0] eidx_r, eidx_nxt;
  status_t est_r, est_nxt;
  logic ov_r, ov_nxt, olast_r, olast_nxt;
  logic [IDX_W-1:0] oidx_r, oidx_nxt;
  status_t ost_r, ost_nxt;

  logic [FILL_W-1:0] fill_rd_r;
  logic [IDX_W-1:0]  memb_rd_r;
  logic [CELL_W-1:0] home_rd_r;

  logic fill_we, fill_re, memb_we, memb_re, home_we, home_re;
  logic [CELL_W-1:0] fill_wa, fill_ra;
  logic [FILL_W-1:0] fill_wd;
  logic [MEM_AW-1:0] memb_wa, memb_ra;
  logic [PIDX_W-1:0] home_wa, home_ra;

  logic out_free, push;
  logic [IDX_W-1:0] push_idx;
  status_t push_st;
  logic push_last;

  nb_off_t off;
  logic signed [7:0] nx, ny;
  logic nb_ok;
  logic [CELL_W-1:0] nb_cell;
  logic [CELL_W-1:0] ins_cell;

  assign out_free = !ov_r || out_ready;
  assign busy = (st_r == B_INIT);
  assign out_valid = ov_r;
  assign out_idx = oidx_r;
  assign out_status = ost_r;
  assign out_last = olast_r;
  assign ins_cell = {cmd_r.cy, cmd_r.cx};

  // neighbour cell for the current step, clipped to the grid in use
  always_comb begin
    off = nb_offset(nb_r);
    nx = $signed({2'b00, cx_r}) + $signed({{6{off.dx[1]}}, off.dx});
    ny = $signed({2'b00, cy_r}) + $signed({{6{off.dy[1]}}, off.dy});
    nb_ok = (nb_r == 4'(NB_LAST)) ||
            (nx >= 0 && ny >= 0 &&
             nx < $signed({1'b0, across}) && ny < $signed({1'b0, down}));
    nb_cell = {ny[COORD_W-1:0], nx[COORD_W-1:0]};
  end

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      B_INIT: if (sweep_r == (CELL_W+1)'(NUM_CELLS - 1)) st_nxt = B_IDLE;
      B_IDLE: begin
        if (cmd_valid) begin
          case (cmd.kind)
            K_INSERT: st_nxt = (total_r >= TOTAL_W'(MAX_PARTICLES)) ? B_EMIT : B_INS_RD;
            K_QUERY:  st_nxt = ({1'b0, cmd.pidx} >= total_r) ? B_EMIT : B_Q_HOME;
            K_CLEAR:  st_nxt = B_CLR;
            default:  st_nxt = B_IDLE;
          endcase
        end
      end
      B_INS_RD:  st_nxt = B_INS_CHK;
      B_INS_CHK: st_nxt = B_EMIT;
      B_EMIT:    if (out_free) st_nxt = B_IDLE;
      B_CLR:     if (sweep_r == (CELL_W+1)'(NUM_CELLS - 1)) st_nxt = B_EMIT;
      B_Q_HOME:  st_nxt = B_Q_CELL;
      B_Q_CELL:  if (nb_ok) st_nxt = B_Q_FILL;
      B_Q_FILL:  st_nxt = B_Q_SLOT;
      B_Q_SLOT: begin
        if (s_r < n_r) st_nxt = B_Q_MEM;
        else if (nb_r == 4'(NB_LAST)) st_nxt = B_Q_END;
        else st_nxt = B_Q_CELL;
      end
      B_Q_MEM:   if (!hold_v_r || out_free) st_nxt = B_Q_SLOT;
      B_Q_END:   if (out_free) st_nxt = B_IDLE;
      default:   st_nxt = B_IDLE;
    endcase
  end

  always_comb begin
    cmd_nxt = cmd_r;
    sweep_nxt = sweep_r;
    total_nxt = total_r;
    cx_nxt = cx_r;
    cy_nxt = cy_r;
    ncell_nxt = ncell_r;
    nb_nxt = nb_r;
    n_nxt = n_r;
    s_nxt = s_r;
    hold_v_nxt = hold_v_r;
    hold_nxt = hold_r;
    eidx_nxt = eidx_r;
    est_nxt = est_r;
    cmd_pop = 1'b0;
    fill_we = 1'b0;
    fill_wa = sweep_r[CELL_W-1:0];
    fill_wd = '0;
    fill_re = 1'b0;
    fill_ra = ins_cell;
    memb_we = 1'b0;
    memb_wa = {ins_cell, fill_rd_r[SLOT_W-1:0]};
    memb_re = 1'b0;
    memb_ra = {ncell_r, s_r[SLOT_W-1:0]};
    home_we = 1'b0;
    home_wa = total_r[PIDX_W-1:0];
    home_re = 1'b0;
    home_ra = cmd.pidx[PIDX_W-1:0];
    push = 1'b0;
    push_idx = eidx_r;
    push_st = est_r;
    push_last = 1'b1;
    case (st_r)
      B_INIT, B_CLR: begin
        fill_we = 1'b1;
        sweep_nxt = sweep_r + 1'b1;
      end
      B_IDLE: begin
        sweep_nxt = '0;
        eidx_nxt = '0;
        if (cmd_valid) begin
          cmd_pop = 1'b1;
          cmd_nxt = cmd;
          case (cmd.kind)
            K_INSERT: est_nxt = ST_TABLE_FULL;
            K_QUERY: begin
              est_nxt = ST_UNKNOWN;
              home_re = 1'b1;
            end
            K_CLEAR: begin
              est_nxt = ST_OK;
              total_nxt = '0;
            end
            default: ;
          endcase
        end
      end
      B_INS_RD: fill_re = 1'b1;
      B_INS_CHK: begin
        if (fill_rd_r >= FILL_W'(MAX_PER_CELL)) begin
          est_nxt = ST_CELL_FULL;
        end else begin
          fill_we = 1'b1;
          fill_wa = ins_cell;
          fill_wd = fill_rd_r + 1'b1;
          memb_we = 1'b1;
          home_we = 1'b1;
          total_nxt = total_r + 1'b1;
          eidx_nxt = total_r[IDX_W-1:0];
          est_nxt = ST_OK;
        end
      end
      B_EMIT: push = out_free;
      B_Q_HOME: begin
        cx_nxt = home_rd_r[COORD_W-1:0];
        cy_nxt = home_rd_r[CELL_W-1:COORD_W];
        nb_nxt = '0;
        hold_v_nxt = 1'b0;
      end
      B_Q_CELL: begin
        if (nb_ok) begin
          fill_re = 1'b1;
          fill_ra = nb_cell;
          ncell_nxt = nb_cell;
        end else begin
          nb_nxt = nb_r + 4'd1;
        end
      end
      B_Q_FILL: begin
        n_nxt = fill_rd_r;
        s_nxt = '0;
      end
      B_Q_SLOT: begin
        if (s_r < n_r) memb_re = 1'b1;
        else if (nb_r != 4'(NB_LAST)) nb_nxt = nb_r + 4'd1;
      end
      B_Q_MEM: begin
        // the previous candidate goes out only once the next is known
        if (!hold_v_r || out_free) begin
          push = hold_v_r;
          push_idx = hold_r;
          push_st = ST_OK;
          push_last = 1'b0;
          hold_nxt = memb_rd_r;
          hold_v_nxt = 1'b1;
          s_nxt = s_r + 1'b1;
        end
      end
      B_Q_END: begin
        push = out_free;
        push_idx = hold_v_r ? hold_r : '0;
        push_st = hold_v_r ? ST_OK : ST_NO_ENTRY;
      end
      default: ;
    endcase
  end

  always_comb begin
    ov_nxt = push ? 1'b1 : (out_ready ? 1'b0 : ov_r);
    oidx_nxt = push ? push_idx : oidx_r;
    ost_nxt = push ? push_st : ost_r;
    olast_nxt = push ? push_last : olast_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= B_INIT;
      sweep_r <= '0;
      total_r <= '0;
      ov_r <= 1'b0;
      hold_v_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      sweep_r <= sweep_nxt;
      total_r <= total_nxt;
      ov_r <= ov_nxt;
      hold_v_r <= hold_v_nxt;
    end
    cmd_r <= cmd_nxt;
    cx_r <= cx_nxt;
    cy_r <= cy_nxt;
    ncell_r <= ncell_nxt;
    nb_r <= nb_nxt;
    n_r <= n_nxt;
    s_r <= s_nxt;
    hold_r <= hold_nxt;
    eidx_r <= eidx_nxt;
    est_r <= est_nxt;
    oidx_r <= oidx_nxt;
    ost_r <= ost_nxt;
    olast_r <= olast_nxt;
  end

  always_ff @(posedge clk) begin
    if (fill_we) fill_mem[fill_wa] <= fill_wd;
    if (fill_re) fill_rd_r <= fill_mem[fill_ra];
  end

  always_ff @(posedge clk) begin
    if (memb_we) memb_mem[memb_wa] <= total_r[IDX_W-1:0];
    if (memb_re) memb_rd_r <= memb_mem[memb_ra];
  end

  always_ff @(posedge clk) begin
    if (home_we) home_mem[home_wa] <= ins_cell;
    if (home_re) home_rd_r <= home_mem[home_ra];
  end

  `CLNS_ASSERT(a_total_bound, clk, rst_n, total_r <= TOTAL_W'(MAX_PARTICLES), "particle count past table size")
  `CLNS_ASSERT(a_no_push_in_sweep, clk, rst_n, (st_r == B_INIT || st_r == B_CLR) |-> !push, "result during clearing sweep")
  `CLNS_ASSERT(a_pop_idle, clk, rst_n, cmd_pop |-> (st_r == B_IDLE && cmd_valid), "command taken outside idle")
  `CLNS_ASSERT_NEXT(a_fill_bound, clk, rst_n, fill_re, fill_rd_r <= FILL_W'(MAX_PER_CELL), "cell fill past capacity")
endmodule
`default_nettype wire

>>> hw/rtl/cell_list_neighbor_search_core.sv
// 2-d cell list neighbour search core: registers, front, queue and back end
// depends on clns_pkg, clns_front, clns_fifo, clns_back
`timescale 1ns / 1ps
`default_nettype none
// Bins particles into a grid of up to 64 x 64 cells and lists the candidates of
// the 3x3 cell neighbourhood of a stored particle. in_tuser selects insert (0),
// query (1) or clear (2); code 3 is swallowed without a result. Every insert,
// query or clear beat ends in a run of result beats on the out side, closed by
// tlast. After reset and on every clear the back end sweeps the 4096-entry cell
// fill memory, one cell a cycle; the block takes no beat until the sweep after
// reset is done, and a clear result appears once its sweep ends. An insert
// passes through the front end's bit-serial dividers (both axes divided side by
// side), which take no new beat until it is done, and then the back end. A query
// reads the home cell of the particle, then the fill and the members of each
// cell it visits, clipped cells skipped, and returns up to 36 entries for a full
// neighbourhood. A queue of four commands between front and back lets the
// dividers work on the next insert while a query is still walking.
module cell_list_neighbor_search_core (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // input beats
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [47:0] in_tdata,   // pos_x[15:0], pos_y[31:16], particle_index[41:32], zero
  input  wire logic [1:0]  in_tuser,   // kind[1:0]
  // result beats
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [15:0]      out_tdata,  // found_index[9:0], status[12:10], zero
  output logic             out_tlast,
  // register writes
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_wdata
);
  import clns_pkg::*;

  logic [POS_W-1:0] cell_size_r;
  logic [SIDE_W-1:0] across_r, down_r;
  logic [SIDE_W-1:0] across, down;
  logic busy, q_push, q_pop, q_full, q_empty;
  cmd_t q_in, q_out;
  logic [IDX_W-1:0] res_idx;
  logic [2:0] res_st;

  // grid sizes are used clamped to 1..64
  assign across = clamp_side(across_r);
  assign down = clamp_side(down_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cell_size_r <= POS_W'(256);
      across_r <= SIDE_W'(MAX_CELLS_SIDE);
      down_r <= SIDE_W'(MAX_CELLS_SIDE);
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_CELL_SIZE: cell_size_r <= cfg_wdata;
        CFG_ACROSS:    across_r <= cfg_wdata[SIDE_W-1:0];
        CFG_DOWN:      down_r <= cfg_wdata[SIDE_W-1:0];
        default: ;
      endcase
    end
  end

  clns_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_kind   (in_tuser),
    .in_pos_x  (in_tdata[15:0]),
    .in_pos_y  (in_tdata[31:16]),
    .in_pidx   (in_tdata[41:32]),
    .cell_size (cell_size_r),
    .across    (across),
    .down      (down),
    .busy      (busy),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_cmd     (q_in)
  );

  clns_fifo u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .din   (q_in),
    .pop   (q_pop),
    .dout  (q_out),
    .full  (q_full),
    .empty (q_empty)
  );

  clns_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd_valid  (!q_empty),
    .cmd        (q_out),
    .cmd_pop    (q_pop),
    .across     (across),
    .down       (down),
    .busy       (busy),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_idx    (res_idx),
    .out_status (res_st),
    .out_last   (out_tlast)
  );

  assign out_tdata = {3'b000, res_st, res_idx};
endmodule
`default_nettype wire
